// ----- rtl/tbme_pkg.sv -----
// tbme_pkg: widths, register indexes, divider operand codes and the
// command/status structs shared by the controller and the datapath.
// No dependencies.
package tbme_pkg;

  localparam int SAMPLE_W = 24;
  localparam int TIME_W   = 31;
  localparam int LEN_W    = 24;
  localparam int START_W  = 32;
  localparam int SUM_W    = 40;
  localparam int SQSUM_W  = 64;
  localparam int COUNT_W  = 16;
  localparam int DIV_W    = 64;

  localparam logic [COUNT_W-1:0]  MAX_PER_BIN = 16'd65535;
  localparam int                  FRAC_BITS   = 8;
  localparam logic [SAMPLE_W-1:0] ONE_FIX     = SAMPLE_W'(1) << FRAC_BITS;
  localparam logic [START_W-1:0]  START_RESET = 32'd1217116818;
  localparam logic [LEN_W-1:0]    LEN_RESET   = 24'd86400;

  localparam logic REG_START = 1'b0;
  localparam logic REG_LEN   = 1'b1;

  localparam logic [1:0] DSEL_MEAN = 2'd0;
  localparam logic [1:0] DSEL_QN   = 2'd1;
  localparam logic [1:0] DSEL_VN   = 2'd2;
  localparam logic [1:0] DSEL_SKIP = 2'd3;

  typedef struct packed {
    logic       load_in;
    logic       eval;
    logic       div_start;
    logic [1:0] div_sel;
    logic       cap_mean;
    logic       cap_qn;
    logic       sqrt_start;
    logic       emit;
    logic       update;
    logic       skip_apply;
  } cmd_t;

  typedef struct packed {
    logic emit_need;
    logic single;
    logic skip;
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } stat_t;

endpackage

// ----- rtl/tbme_div.sv -----
// tbme_div: iterative restoring divider, one quotient bit per cycle.
// 64-bit dividend, 24-bit divisor. Depends on tbme_pkg.
module tbme_div import tbme_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [LEN_W-1:0]  divisor,
  output logic              done,
  output logic [DIV_W-1:0]  quotient,
  output logic [LEN_W-1:0]  remainder
);

  logic             busy;
  logic [5:0]       cnt;
  logic [LEN_W-1:0] dvs;
  logic [LEN_W-1:0] rem;
  logic [DIV_W-1:0] quo;
  logic [LEN_W:0]   rem_sh;
  logic             ge;
  logic [LEN_W:0]   rem_sub;

  assign rem_sh  = {rem, quo[DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs};
  assign rem_sub = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd63;
        dvs  <= divisor;
        rem  <= '0;
        quo  <= dividend;
      end else if (busy) begin
        rem <= ge ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
        quo <= {quo[DIV_W-2:0], ge};
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 6'd1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ----- rtl/tbme_sqrt.sv -----
// tbme_sqrt: digit-by-digit integer square root, one root bit per cycle.
// 64-bit operand, 32-bit floor root. Depends on tbme_pkg.
module tbme_sqrt import tbme_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] operand,
  output logic             done,
  output logic [31:0]      root
);

  logic             busy;
  logic [4:0]       cnt;
  logic [DIV_W-1:0] xr;
  logic [33:0]      rem;
  logic [35:0]      rem_sh;
  logic [35:0]      trial;
  logic [35:0]      rem_sub;
  logic             ge;

  assign rem_sh  = {rem, xr[DIV_W-1:DIV_W-2]};
  assign trial   = {2'b00, root, 2'b01};
  assign ge      = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd31;
        xr   <= operand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rem  <= ge ? rem_sub[33:0] : rem_sh[33:0];
        root <= {root[30:0], ge};
        xr   <= {xr[DIV_W-3:0], 2'b00};
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

endmodule

// ----- rtl/tbme_dp.sv -----
// tbme_dp: bin accumulators, bin timing, result register, shared divider
// and square root unit. Depends on tbme_pkg, tbme_div, tbme_sqrt.
module tbme_dp import tbme_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [TIME_W-1:0]   cfg_data,
  input  logic [SAMPLE_W-1:0] sample_value,
  input  logic [TIME_W-1:0]   time_stamp,
  input  cmd_t                cmd,
  output stat_t               stat,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SAMPLE_W-1:0] bin_mean,
  output logic [SAMPLE_W-1:0] bin_error,
  output logic [START_W-1:0]  bin_center
);

  logic [LEN_W-1:0]    bin_length;
  logic [START_W-1:0]  bin_start;
  logic [SUM_W-1:0]    value_sum;
  logic [SQSUM_W-1:0]  square_sum;
  logic [COUNT_W-1:0]  sample_count;

  logic [SAMPLE_W-1:0] smp;
  logic [TIME_W-1:0]   ts;
  logic [32:0]         d;
  logic [47:0]         sq;
  logic [SAMPLE_W-1:0] mean;
  logic [DIV_W-1:0]    qn;
  logic [47:0]         m2;

  logic [LEN_W-1:0]    len;
  logic                close;
  logic                skip;
  logic [DIV_W-1:0]    v;
  logic [SUM_W:0]      mean_num;
  logic [DIV_W-1:0]    div_a;
  logic [LEN_W-1:0]    div_b;
  logic                div_done;
  logic [DIV_W-1:0]    div_q;
  logic [LEN_W-1:0]    div_r;
  logic                sqrt_done;
  logic [31:0]         sqrt_root;
  logic                take;
  logic [COUNT_W-1:0]  cnt_base;

  assign len      = (bin_length == '0) ? LEN_W'(1) : bin_length;
  assign close    = $signed(d) > $signed({9'b0, len});
  assign skip     = $signed(d) > $signed({8'b0, len, 1'b0});
  assign v        = (qn > {16'b0, m2}) ? qn - {16'b0, m2} : '0;
  assign mean_num = {1'b0, value_sum} + {26'b0, sample_count[COUNT_W-1:1]};

  always_comb begin
    div_a = '0;
    div_b = {8'b0, sample_count};
    unique case (cmd.div_sel)
      DSEL_MEAN: div_a = {23'b0, mean_num};
      DSEL_QN:   div_a = square_sum;
      DSEL_VN:   div_a = v;
      DSEL_SKIP: begin
        div_a = {31'b0, d};
        div_b = len;
      end
      default:   div_a = '0;
    endcase
  end

  tbme_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  tbme_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.sqrt_start),
    .operand (div_q),
    .done    (sqrt_done),
    .root    (sqrt_root)
  );

  // count after a possible bin close, used for the full-bin check
  assign cnt_base = close ? '0 : sample_count;
  assign take     = (smp != '0) && (cnt_base < MAX_PER_BIN);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      smp <= sample_value;
      ts  <= time_stamp;
    end
    if (cmd.eval) begin
      d  <= {2'b0, ts} - {1'b0, bin_start};
      sq <= smp * smp;
    end
    if (cmd.cap_mean) begin
      mean <= div_q[SAMPLE_W-1:0];
    end
    if (cmd.cap_qn) begin
      qn <= div_q;
      m2 <= mean * mean;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_length   <= LEN_RESET;
      bin_start    <= START_RESET;
      value_sum    <= '0;
      square_sum   <= '0;
      sample_count <= '0;
    end else begin
      if (cmd.update) begin
        if (take) begin
          value_sum    <= (close ? '0 : value_sum) + {16'b0, smp};
          square_sum   <= (close ? '0 : square_sum) + {16'b0, sq};
          sample_count <= cnt_base + COUNT_W'(1);
        end else if (close) begin
          value_sum    <= '0;
          square_sum   <= '0;
          sample_count <= '0;
        end
        if (close && !skip) begin
          bin_start <= bin_start + {8'b0, len};
        end
      end
      // skip lands on old start plus whole bins up to the sample
      if (cmd.skip_apply) begin
        bin_start <= bin_start + d[31:0] - {8'b0, div_r};
      end
      if (cfg_write) begin
        unique case (cfg_index)
          REG_START: begin
            bin_start    <= {1'b0, cfg_data};
            value_sum    <= '0;
            square_sum   <= '0;
            sample_count <= '0;
          end
          REG_LEN: bin_length <= cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      bin_mean   <= mean;
      bin_center <= bin_start + {9'b0, len[LEN_W-1:1]};
      if (sample_count == COUNT_W'(1)) begin
        bin_error <= ONE_FIX;
      end else if (sqrt_root[31:SAMPLE_W] != '0) begin
        bin_error <= '1;
      end else begin
        bin_error <= sqrt_root[SAMPLE_W-1:0];
      end
    end
  end

  assign stat.emit_need = close && (sample_count != '0);
  assign stat.single    = sample_count == COUNT_W'(1);
  assign stat.skip      = skip;
  assign stat.div_done  = div_done;
  assign stat.sqrt_done = sqrt_done;
  assign stat.out_free  = !out_valid;

endmodule

// ----- rtl/tbme_ctrl.sv -----
// tbme_ctrl: sequencing state machine for one word at a time.
// Drives the datapath commands. Depends on tbme_pkg.
module tbme_ctrl import tbme_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EVAL   = 4'd1;
  localparam logic [3:0] S_DECIDE = 4'd2;
  localparam logic [3:0] S_DMEAN  = 4'd3;
  localparam logic [3:0] S_DQN    = 4'd4;
  localparam logic [3:0] S_V      = 4'd5;
  localparam logic [3:0] S_DVN    = 4'd6;
  localparam logic [3:0] S_SQRT   = 4'd7;
  localparam logic [3:0] S_EMIT   = 4'd8;
  localparam logic [3:0] S_UPD    = 4'd9;
  localparam logic [3:0] S_DSKIP  = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.emit_need) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DSEL_MEAN;
          state_next    = S_DMEAN;
        end else begin
          state_next = S_UPD;
        end
      end
      S_DMEAN: begin
        if (stat.div_done) begin
          cmd.cap_mean = 1'b1;
          if (stat.single) begin
            state_next = S_EMIT;
          end else begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DSEL_QN;
            state_next    = S_DQN;
          end
        end
      end
      S_DQN: begin
        if (stat.div_done) begin
          cmd.cap_qn = 1'b1;
          state_next = S_V;
        end
      end
      S_V: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_VN;
        state_next    = S_DVN;
      end
      S_DVN: begin
        if (stat.div_done) begin
          cmd.sqrt_start = 1'b1;
          state_next     = S_SQRT;
        end
      end
      S_SQRT: begin
        if (stat.sqrt_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        if (stat.skip) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DSEL_SKIP;
          state_next    = S_DSKIP;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DSKIP: begin
        cmd.div_sel = DSEL_SKIP;
        if (stat.div_done) begin
          cmd.skip_apply = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/time_binned_mean_and_error.sv -----
// time_binned_mean_and_error: one word at a time. Closing a bin that held samples
// adds three divider passes, a square root and an emit step (one divider pass and
// the emit step when the bin held one sample), and a gap skip adds one more
// divider pass, plus any wait for the receiver to take the previous result.
// Throughput is set by the shared one-bit-per-cycle divider.
// Reset (synchronous) loads the default start time and bin length, clears sums.
module time_binned_mean_and_error import tbme_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [TIME_W-1:0]   cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] sample_value,
  input  logic [TIME_W-1:0]   time_stamp,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SAMPLE_W-1:0] bin_mean,
  output logic [SAMPLE_W-1:0] bin_error,
  output logic [START_W-1:0]  bin_center
);

  cmd_t  cmd;
  stat_t stat;

  tbme_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tbme_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_value (sample_value),
    .time_stamp   (time_stamp),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .bin_mean     (bin_mean),
    .bin_error    (bin_error),
    .bin_center   (bin_center)
  );

endmodule

// ----- tb/sv/tb.sv -----
// tb: self-checking bench for time_binned_mean_and_error; predicts each closed
// bin's mean, standard error and centre and compares against the block output.
// Depends on tbme_pkg and the time_binned_mean_and_error RTL.
module tb;
  import tbme_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  logic                cfg_index = REG_START;
  logic [TIME_W-1:0]   cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [SAMPLE_W-1:0] sample_value = '0;
  logic [TIME_W-1:0]   time_stamp = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [SAMPLE_W-1:0] bin_mean;
  logic [SAMPLE_W-1:0] bin_error;
  logic [START_W-1:0]  bin_center;

  typedef struct packed {
    logic [SAMPLE_W-1:0] mean;
    logic [SAMPLE_W-1:0] err;
    logic [START_W-1:0]  center;
  } bin_stats_t;

  bin_stats_t  pending_bins[$];
  int          fail_count = 0;
  bit          hold_off = 1'b0;

  // predictor state
  logic [LEN_W-1:0]   p_bin_len;
  logic [START_W-1:0] p_bin_start;
  logic [63:0]        p_sum;
  logic [63:0]        p_sq;
  logic [COUNT_W-1:0] p_cnt;

  time_binned_mean_and_error uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #200ms;
    $display("time_binned_mean_and_error verification failed");
    $finish;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic predict_bin(logic [SAMPLE_W-1:0] s, logic [TIME_W-1:0] ts);
    logic [63:0] len;
    logic signed [63:0] d;
    logic [63:0] n;
    logic [63:0] mean;
    logic [63:0] e;
    logic [63:0] qn;
    logic [63:0] m2;
    logic [63:0] v;
    bin_stats_t r;
    len = (p_bin_len == 0) ? 64'd1 : 64'(p_bin_len);
    d = $signed(64'(ts)) - $signed(64'(p_bin_start));
    if (d > $signed(len)) begin
      if (p_cnt > 0) begin
        n = 64'(p_cnt);
        mean = (p_sum + n / 2) / n;
        if (n > 1) begin
          qn = p_sq / n;
          m2 = mean * mean;
          v = (qn > m2) ? qn - m2 : 64'd0;
          e = int_sqrt(v / n);
          if (e > 64'hFFFFFF) e = 64'hFFFFFF;
        end else begin
          e = 64'(ONE_FIX);
        end
        r.mean = mean[SAMPLE_W-1:0];
        r.err = e[SAMPLE_W-1:0];
        r.center = 32'(64'(p_bin_start) + len / 2);
        pending_bins = {pending_bins, r};
      end
      p_sum = 0;
      p_sq = 0;
      p_cnt = 0;
      p_bin_start = 32'(64'(p_bin_start) + len);
    end
    if (s > 0 && p_cnt < MAX_PER_BIN) begin
      p_sum += 64'(s);
      p_sq += 64'(s) * 64'(s);
      p_cnt++;
    end
    if (d > $signed(2 * len))
      p_bin_start = 32'(64'(p_bin_start) + len * (64'(d) / len) - len);
  endtask

  task automatic write_reg(logic idx, logic [TIME_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_START) begin
      p_bin_start = 32'(val);
      p_sum = 0;
      p_sq = 0;
      p_cnt = 0;
    end else begin
      p_bin_len = val[LEN_W-1:0];
    end
    @(posedge clk);
  endtask

  // wait until every bin has come out, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // valid stays high into the next word when there is no gap
  task automatic send_word(logic [SAMPLE_W-1:0] s, logic [TIME_W-1:0] ts, bit gaps = 1);
    int w;
    w = gaps ? $urandom_range(0, 10) : 0;
    if ($urandom_range(0, 3) == 0) w = 0;
    if (w > 0) begin
      in_valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_value <= s;
    time_stamp <= ts;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_bin(s, ts);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_bins.size() == 0) begin
        $error("bin result with none expected");
        fail_count++;
      end else begin
        bin_stats_t x;
        x = pending_bins.pop_front();
        if (bin_mean !== x.mean) begin
          $error("bin_mean exp %0d got %0d", x.mean, bin_mean);
          fail_count++;
        end
        if (bin_error !== x.err) begin
          $error("bin_error exp %0d got %0d", x.err, bin_error);
          fail_count++;
        end
        if (bin_center !== x.center) begin
          $error("bin_center exp %0d got %0d", x.center, bin_center);
          fail_count++;
        end
      end
    end
  end

  // receiver stalls: random per result, or one long hold-off when asked
  initial begin
    int w;
    @(negedge rst);
    forever begin
      w = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) w = 0;
      if (hold_off) begin
        w = 3000;
        hold_off = 1'b0;
      end
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  task automatic test_directed();
    logic [TIME_W-1:0] t;
    t = 31'd1217116818;
    // several samples in the first bin, including the largest value and zero
    send_word(24'hFFFFFF, t);
    send_word(24'd1, t + 31'd10);
    send_word(24'd0, t + 31'd20);
    send_word(24'd256, t + 31'd86400);
    // closes bin, then a single-sample bin
    send_word(24'd512, t + 31'd86401);
    // gap skip over many bins
    send_word(24'd1000, t + 31'd864000);
    // sample before bin start
    send_word(24'd7, 31'd5);
    send_word(24'd9, t + 31'd1036800);
    send_word(24'd3, 31'h7FFFFFFF);
    send_word(24'd0, 31'd0);
    drain();
    // zero bin length behaves as one
    write_reg(REG_LEN, '0);
    write_reg(REG_START, 31'd100);
    send_word(24'd10, 31'd100);
    send_word(24'd20, 31'd101);
    send_word(24'd30, 31'd102);
    send_word(24'd40, 31'd110);
    send_word(24'd50, 31'd200);
    drain();
    // largest bin length and start time
    write_reg(REG_LEN, 31'hFFFFFF);
    write_reg(REG_START, 31'h7FFFFFFF);
    send_word(24'h800000, 31'h7FFFFFFF);
    send_word(24'h7FFFFF, 31'h7FFFFFFF);
    send_word(24'h1, 31'd0);
    drain();
  endtask

  // many back-to-back samples in one bin with a small length
  task automatic test_full_bin();
    write_reg(REG_LEN, 31'd4);
    write_reg(REG_START, 31'd1000);
    for (int i = 0; i < 40; i++) send_word(24'(1 + (i % 5)), 31'd1001, 0);
    send_word(24'd1, 31'd1006);
    drain();
  endtask

  // receiver stalls a long time while words keep coming
  task automatic test_backpressure();
    write_reg(REG_LEN, 31'd2);
    write_reg(REG_START, 31'd0);
    hold_off = 1'b1;
    for (int i = 0; i < 40; i++) send_word(24'($urandom_range(1, 4000)), 31'(i * 3), 0);
    drain();
  endtask

  task automatic test_random();
    logic [TIME_W-1:0] t;
    logic [SAMPLE_W-1:0] s;
    int k;
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_LEN, 31'($urandom_range(1, 50)));
      if (ph == 7) write_reg(REG_LEN, 31'hFFFFFF);
      t = 31'($urandom_range(0, 32'h7FFF0000));
      write_reg(REG_START, t);
      for (int i = 0; i < 90; i++) begin
        k = $urandom_range(0, 19);
        if (k < 14) t = t + 31'($urandom_range(0, 2 * p_bin_len + 1));
        else if (k < 17) t = t - 31'($urandom_range(0, 30));
        else t = 31'($urandom);
        case ($urandom_range(0, 3))
          0: s = 24'($urandom);
          1: s = 24'($urandom_range(0, 300));
          2: s = 24'hFFFFFF - 24'($urandom_range(0, 5));
          default: s = 24'($urandom_range(200, 70000));
        endcase
        send_word(s, t);
      end
      drain();
    end
  endtask

  initial begin
    p_bin_len = LEN_RESET;
    p_bin_start = START_RESET;
    p_sum = 0;
    p_sq = 0;
    p_cnt = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_bin();
    test_backpressure();
    test_random();
    if (fail_count == 0)
      $display("time_binned_mean_and_error verification clean");
    else
      $display("time_binned_mean_and_error verification failed");
    $finish;
  end

endmodule
